@@ hw/rtl/dtap_pkg.sv @@
// Shared types and constants for the date-time / alarm text parser.
// No dependencies; used by dtap_step, dtap_verdict and the parser core.
package dtap_pkg;

   // Input beat: one character of a message.
   typedef struct packed {
      logic       mode;
      logic [7:0] char_code;
      logic       first_char;
      logic       last_char;
   } req_type;

   // Result beat: verdict and decoded fields.
   typedef struct packed {
      logic       ok;
      logic [6:0] year_of_century;
      logic [3:0] month;
      logic [4:0] day;
      logic [4:0] hour;
      logic [5:0] minute;
      logic [5:0] second;
   } rsp_type;

   // Per-message parse state.
   typedef struct packed {
      logic        mode_latched;
      logic [4:0]  char_position;
      logic        format_good;
      logic [6:0]  month_acc;
      logic [6:0]  day_acc;
      logic [13:0] year_acc;
      logic [6:0]  hour_acc;
      logic [6:0]  minute_acc;
      logic [6:0]  second_acc;
      logic [7:0]  first_raw;
      logic [7:0]  third_raw;
      logic        colon_at_one;
   } parse_state_type;

   localparam logic        MODE_TIME      = 1'b0;

   localparam logic [4:0]  POS_MAX        = 5'd31;
   localparam logic [4:0]  TIME_LEN       = 5'd19;
   localparam logic [4:0]  ALARM_LEN_RAW  = 5'd3;
   localparam logic [4:0]  ALARM_LEN_FULL = 5'd5;

   localparam logic [13:0] YEAR_LO        = 14'd2000;
   localparam logic [13:0] YEAR_HI        = 14'd2099;
   localparam logic [6:0]  MONTH_MAX      = 7'd12;
   localparam logic [6:0]  DAY_MAX        = 7'd31;
   localparam logic [6:0]  HOUR_MAX       = 7'd23;
   localparam logic [6:0]  MIN_MAX        = 7'd59;
   localparam logic [6:0]  SEC_MAX        = 7'd59;

   localparam logic [7:0]  CHAR_ZERO      = 8'h30;
   localparam logic [7:0]  CHAR_NINE      = 8'h39;
   localparam logic [7:0]  CHAR_SLASH     = 8'h2F;
   localparam logic [7:0]  CHAR_COLON     = 8'h3A;
   localparam logic [7:0]  CHAR_SPACE     = 8'h20;

   localparam parse_state_type STATE_CLEAR = '{
      mode_latched:  1'b0,
      char_position: 5'd0,
      format_good:   1'b1,
      month_acc:     7'd0,
      day_acc:       7'd0,
      year_acc:      14'd0,
      hour_acc:      7'd0,
      minute_acc:    7'd0,
      second_acc:    7'd0,
      first_raw:     8'd0,
      third_raw:     8'd0,
      colon_at_one:  1'b0
   };

   function automatic logic is_digit(logic [7:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   // acc * 10 + digit, shift-and-add
   function automatic logic [13:0] dec_push(logic [13:0] acc, logic [3:0] digit);
      return (acc << 3) + (acc << 1) + {10'd0, digit};
   endfunction

endpackage

@@ hw/rtl/dtap_step.sv @@
// Next-state logic for one character: position decode, digit accumulate,
// separator check. Depends on dtap_pkg.
module dtap_step (
   input  dtap_pkg::parse_state_type cur_state,
   input  dtap_pkg::req_type         req_beat,
   output dtap_pkg::parse_state_type nxt_state
);

   // date-time slots, "MM/dd/yyyy HH:mm:ss"
   localparam logic [4:0] TM_MON0  = 5'd0;
   localparam logic [4:0] TM_MON1  = 5'd1;
   localparam logic [4:0] TM_SEP0  = 5'd2;
   localparam logic [4:0] TM_DAY0  = 5'd3;
   localparam logic [4:0] TM_DAY1  = 5'd4;
   localparam logic [4:0] TM_SEP1  = 5'd5;
   localparam logic [4:0] TM_YR0   = 5'd6;
   localparam logic [4:0] TM_YR1   = 5'd7;
   localparam logic [4:0] TM_YR2   = 5'd8;
   localparam logic [4:0] TM_YR3   = 5'd9;
   localparam logic [4:0] TM_GAP   = 5'd10;
   localparam logic [4:0] TM_HR0   = 5'd11;
   localparam logic [4:0] TM_HR1   = 5'd12;
   localparam logic [4:0] TM_SEP2  = 5'd13;
   localparam logic [4:0] TM_MIN0  = 5'd14;
   localparam logic [4:0] TM_MIN1  = 5'd15;
   localparam logic [4:0] TM_SEP3  = 5'd16;
   localparam logic [4:0] TM_SEC0  = 5'd17;
   localparam logic [4:0] TM_SEC1  = 5'd18;

   // alarm slots
   localparam logic [4:0] AL_B0    = 5'd0;
   localparam logic [4:0] AL_B1    = 5'd1;
   localparam logic [4:0] AL_B2    = 5'd2;
   localparam logic [4:0] AL_B3    = 5'd3;
   localparam logic [4:0] AL_B4    = 5'd4;

   always_comb begin
      dtap_pkg::parse_state_type base;
      logic [7:0] c;
      logic       dig;
      logic [3:0] d;

      c   = req_beat.char_code;
      dig = dtap_pkg::is_digit(c);
      d   = c[3:0];

      // a new message starts on first_char or after a result
      if (req_beat.first_char || (cur_state.char_position == 5'd0)) begin
         base              = dtap_pkg::STATE_CLEAR;
         base.mode_latched = req_beat.mode;
      end else begin
         base = cur_state;
      end

      nxt_state = base;

      if (base.mode_latched == dtap_pkg::MODE_TIME) begin
         case (base.char_position)
            TM_MON0, TM_MON1: begin
               if (dig) nxt_state.month_acc =
                  7'(dtap_pkg::dec_push({7'd0, base.month_acc}, d));
               else nxt_state.format_good = 1'b0;
            end
            TM_DAY0, TM_DAY1: begin
               if (dig) nxt_state.day_acc =
                  7'(dtap_pkg::dec_push({7'd0, base.day_acc}, d));
               else nxt_state.format_good = 1'b0;
            end
            TM_YR0, TM_YR1, TM_YR2, TM_YR3: begin
               if (dig) nxt_state.year_acc = dtap_pkg::dec_push(base.year_acc, d);
               else nxt_state.format_good = 1'b0;
            end
            TM_HR0, TM_HR1: begin
               if (dig) nxt_state.hour_acc =
                  7'(dtap_pkg::dec_push({7'd0, base.hour_acc}, d));
               else nxt_state.format_good = 1'b0;
            end
            TM_MIN0, TM_MIN1: begin
               if (dig) nxt_state.minute_acc =
                  7'(dtap_pkg::dec_push({7'd0, base.minute_acc}, d));
               else nxt_state.format_good = 1'b0;
            end
            TM_SEC0, TM_SEC1: begin
               if (dig) nxt_state.second_acc =
                  7'(dtap_pkg::dec_push({7'd0, base.second_acc}, d));
               else nxt_state.format_good = 1'b0;
            end
            TM_SEP0, TM_SEP1: begin
               if (c != dtap_pkg::CHAR_SLASH) nxt_state.format_good = 1'b0;
            end
            TM_GAP: begin
               if (c != dtap_pkg::CHAR_SPACE) nxt_state.format_good = 1'b0;
            end
            TM_SEP2, TM_SEP3: begin
               if (c != dtap_pkg::CHAR_COLON) nxt_state.format_good = 1'b0;
            end
            default: begin
            end
         endcase
      end else begin
         case (base.char_position)
            AL_B0, AL_B1: begin
               if (base.char_position == AL_B0) nxt_state.first_raw = c;
               else nxt_state.colon_at_one = (c == dtap_pkg::CHAR_COLON);
               if (dig) nxt_state.hour_acc =
                  7'(dtap_pkg::dec_push({7'd0, base.hour_acc}, d));
               else nxt_state.format_good = 1'b0;
            end
            AL_B2: begin
               nxt_state.third_raw = c;
               if (c != dtap_pkg::CHAR_COLON) nxt_state.format_good = 1'b0;
            end
            AL_B3, AL_B4: begin
               if (dig) nxt_state.minute_acc =
                  7'(dtap_pkg::dec_push({7'd0, base.minute_acc}, d));
               else nxt_state.format_good = 1'b0;
            end
            default: begin
            end
         endcase
      end

      // saturating character count
      if (base.char_position != dtap_pkg::POS_MAX)
         nxt_state.char_position = base.char_position + 5'd1;
   end

endmodule

@@ hw/rtl/dtap_verdict.sv @@
// Final range checks and result formatting for a finished message.
// Depends on dtap_pkg.
module dtap_verdict (
   input  dtap_pkg::parse_state_type msg_state,
   output dtap_pkg::rsp_type         rsp_beat
);

   always_comb begin
      logic [4:0]  n;
      logic [13:0] yoc;

      n   = msg_state.char_position;
      yoc = msg_state.year_acc - dtap_pkg::YEAR_LO;
      rsp_beat = '0;

      if (msg_state.mode_latched == dtap_pkg::MODE_TIME) begin
         if ((n >= dtap_pkg::TIME_LEN) && msg_state.format_good &&
             (msg_state.month_acc >= 7'd1) && (msg_state.month_acc <= dtap_pkg::MONTH_MAX) &&
             (msg_state.day_acc >= 7'd1) && (msg_state.day_acc <= dtap_pkg::DAY_MAX) &&
             (msg_state.hour_acc <= dtap_pkg::HOUR_MAX) &&
             (msg_state.minute_acc <= dtap_pkg::MIN_MAX) &&
             (msg_state.second_acc <= dtap_pkg::SEC_MAX) &&
             (msg_state.year_acc >= dtap_pkg::YEAR_LO) &&
             (msg_state.year_acc <= dtap_pkg::YEAR_HI)) begin
            rsp_beat.ok              = 1'b1;
            rsp_beat.year_of_century = yoc[6:0];
            rsp_beat.month           = msg_state.month_acc[3:0];
            rsp_beat.day             = msg_state.day_acc[4:0];
            rsp_beat.hour            = msg_state.hour_acc[4:0];
            rsp_beat.minute          = msg_state.minute_acc[5:0];
            rsp_beat.second          = msg_state.second_acc[5:0];
         end
      end else if (n == dtap_pkg::ALARM_LEN_RAW) begin
         if (msg_state.colon_at_one) begin
            // raw binary bytes take precedence over ASCII digits
            if ((msg_state.first_raw <= {1'b0, dtap_pkg::HOUR_MAX}) &&
                (msg_state.third_raw <= {1'b0, dtap_pkg::MIN_MAX})) begin
               rsp_beat.ok     = 1'b1;
               rsp_beat.hour   = msg_state.first_raw[4:0];
               rsp_beat.minute = msg_state.third_raw[5:0];
            end else if (dtap_pkg::is_digit(msg_state.first_raw) &&
                         dtap_pkg::is_digit(msg_state.third_raw)) begin
               rsp_beat.ok     = 1'b1;
               rsp_beat.hour   = {1'b0, msg_state.first_raw[3:0]};
               rsp_beat.minute = {2'b00, msg_state.third_raw[3:0]};
            end
         end
      end else if (n == dtap_pkg::ALARM_LEN_FULL) begin
         if (msg_state.format_good && (msg_state.hour_acc <= dtap_pkg::HOUR_MAX) &&
             (msg_state.minute_acc <= dtap_pkg::MIN_MAX)) begin
            rsp_beat.ok     = 1'b1;
            rsp_beat.hour   = msg_state.hour_acc[4:0];
            rsp_beat.minute = msg_state.minute_acc[5:0];
         end
      end
   end

endmodule

@@ hw/rtl/datetime_and_alarm_text_parser_core.sv @@
// A result beat is registered and appears in the cycle after the last character is accepted.
// Throughput: 1 character per cycle; the parse state updates in a single pass
// from the accepted beat, and the result lands in one output register.
// Input stalls only while a result sits in the output register and is stalled.
// Reset (synchronous, active high): parse state cleared, output register empty.
// Depends on dtap_pkg, dtap_step, dtap_verdict.
module datetime_and_alarm_text_parser_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  dtap_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output dtap_pkg::rsp_type rsp_data
);

   // parse state carried between characters
   dtap_pkg::parse_state_type state_ff, state_in;
   dtap_pkg::parse_state_type step_state;

   // output register (one result beat)
   logic              rsp_valid_ff, rsp_valid_in;
   dtap_pkg::rsp_type rsp_data_ff, rsp_data_in;
   dtap_pkg::rsp_type verdict;

   logic req_accept;

   // only a held, stalled result blocks new characters
   assign req_stall  = rsp_valid_ff && rsp_stall;
   assign req_accept = req_valid && !req_stall;

   // next parse state for the incoming character
   dtap_step u_step (
      .cur_state (state_ff),
      .req_beat  (req_data),
      .nxt_state (step_state)
   );

   // verdict evaluated on the state including this character
   dtap_verdict u_verdict (
      .msg_state (step_state),
      .rsp_beat  (verdict)
   );

   always_comb begin
      state_in = state_ff;
      if (req_accept) begin
         state_in = step_state;
         // a result closes the message; zero count forces a fresh start
         if (req_data.last_char) state_in.char_position = 5'd0;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (req_accept && req_data.last_char) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = verdict;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= dtap_pkg::STATE_CLEAR;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload register, no reset needed
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // a new result only follows an accepted last character
   a_rsp_from_last: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(req_accept && req_data.last_char))
      else $error("result beat without a last character");

   // the message count restarts after each result
   a_pos_cleared: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.last_char) |=> (state_ff.char_position == 5'd0))
      else $error("char position not cleared after result");

   // a failed result carries only zero fields
   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_data_ff.ok) |->
         (rsp_data_ff.year_of_century == 7'd0 && rsp_data_ff.month == 4'd0 &&
          rsp_data_ff.day == 5'd0 && rsp_data_ff.hour == 5'd0 &&
          rsp_data_ff.minute == 6'd0 && rsp_data_ff.second == 6'd0))
      else $error("failed result with nonzero fields");

   // alarm results never carry date or seconds fields
   a_alarm_fields: assert property (@(posedge clock) disable iff (reset)
      (req_accept && req_data.last_char &&
       step_state.mode_latched != dtap_pkg::MODE_TIME) |=>
         (rsp_data_ff.year_of_century == 7'd0 && rsp_data_ff.month == 4'd0 &&
          rsp_data_ff.day == 5'd0 && rsp_data_ff.second == 6'd0))
      else $error("alarm result with date fields");

endmodule
